/* sv/t8cpu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t8cpu_pkg
// opcodes, word kinds, result classes and the packed result word of the
// tiny 8-bit cpu execute unit
// ----------------------------------------------------------------------------
package t8cpu_pkg;

   // stream widths
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 48;

   // machine constants
   localparam int NUM_REGS  = 16;
   localparam int BYTE_SPAN = 256;
   localparam logic [7:0] PC_STEP = 8'd2;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_INC  = 4'd3,
      OP_AND  = 4'd4,
      OP_OR   = 4'd5,
      OP_XOR  = 4'd6,
      OP_NOT  = 4'd7,
      OP_SLLI = 4'd8,
      OP_SRLI = 4'd9,
      OP_LI   = 4'd10,
      OP_LD   = 4'd11,
      OP_ST   = 4'd12,
      OP_JMP  = 4'd13,
      OP_BEQZ = 4'd14,
      OP_HLT  = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_EXEC     = 2'd0,
      KIND_LOAD_REG = 2'd1,
      KIND_LOAD_MEM = 2'd2,
      KIND_READ_MEM = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CLASS_ARITH = 3'd0,
      CLASS_LOGIC = 3'd1,
      CLASS_SHIFT = 3'd2,
      CLASS_MEM   = 3'd3,
      CLASS_IMM   = 3'd4,
      CLASS_CTRL  = 3'd5,
      CLASS_HALT  = 3'd6
   } inst_class_type;

   // result word, first field in the highest bits
   typedef struct packed {
      inst_class_type inst_class;
      logic [7:0]     store_byte;
      logic [7:0]     store_addr;
      logic           store_done;
      logic [7:0]     dest_value;
      logic [3:0]     dest_index;
      logic           reg_written;
      logic           halted;
      logic [7:0]     next_pc;
   } rsp_word_type;

   // register file write carried from execute to the result stage
   typedef struct packed {
      logic       we;
      logic       from_mem;
      logic [3:0] idx;
      logic [7:0] val;
   } rf_wr_type;

endpackage

/* sv/tiny_8bit_cpu_execute_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_execute_unit
// executes one 16-bit instruction of a 16-opcode 8-bit machine per word,
// with register and data byte preload and data byte readout
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+----------
//  req     | in  | tdata: instr_word, target_addr, load_value       | tvalid/
//          |     | tuser: kind                                      | tready
//  rsp     | out | tdata: next_pc .. inst_class (42 bits + zeros)   | tvalid/
//          |     |                                                  | tready
//
//  one word enters per cycle unless a stalled rsp holds it back; each word
//  is registered in execute (capture and operand read), then executed into
//  the result register, which drives rsp_tvalid
//  the data memory read for LD and readout is the registered read of the
//  single memory port, taken on the execute-to-result transfer
//  reset clears the valid bits, program counter and halt flag; registers
//  and data memory hold no defined value until written
//  a stalled rsp holds the result stage; req stays open while execute is
//  empty or can move on into the result stage
//
module tiny_8bit_cpu_execute_unit #(
   parameter int DATA_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // instr_word [15:0], target_addr [23:16], load_value [31:24]
   input  logic [t8cpu_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind [1:0]
   input  logic [t8cpu_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_pc [7:0], halted [8], reg_written [9], dest_index [13:10],
   // dest_value [21:14], store_done [22], store_addr [30:23],
   // store_byte [38:31], inst_class [41:39], zeros above
   output logic [t8cpu_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import t8cpu_pkg::*;

   localparam int ADDR_W = $clog2(DATA_DEPTH);

   // byte address reduced into the data memory, a constant table
   logic [ADDR_W-1:0] mod_tbl [BYTE_SPAN];

   for (genvar i = 0; i < BYTE_SPAN; i++) begin : g_mod_tbl
      assign mod_tbl[i] = ADDR_W'(i % DATA_DEPTH);
   end

   // ---------------------------------------------------------------- storage
   logic [7:0] rf_ff [NUM_REGS];
   logic [7:0] data_mem [DATA_DEPTH];
   logic [7:0] mem_rdata_ff;
   logic [7:0] pc_ff, pc_in;
   logic       halt_ff, halt_in;

   // ---------------------------------------------------------- handshakes
   logic req_accept;
   logic m_ready;
   logic e_adv;

   // execute stage
   logic       e_valid_ff;
   kind_type   e_kind_ff;
   logic [15:0] e_instr_ff;
   logic [7:0] e_target_ff;
   logic [7:0] e_load_ff;
   logic [7:0] e_src1_ff;
   logic [7:0] e_src2_ff;

   // result stage
   logic         m_valid_ff;
   rsp_word_type m_word_ff, m_word_in;
   rf_wr_type    m_rf_ff, m_rf_in;
   logic         m_rd_ff, m_rd_in;

   assign m_ready    = !m_valid_ff || rsp_tready;
   assign e_adv      = e_valid_ff && m_ready;
   assign req_tready = !e_valid_ff || m_ready;
   assign req_accept = req_tvalid && req_tready;

   // ------------------------------------------------- register file write
   // registers are written when the result word leaves, load data included
   logic       rf_we;
   logic [7:0] rf_wdata;

   assign rf_we    = m_valid_ff && rsp_tready && m_rf_ff.we;
   assign rf_wdata = m_rf_ff.from_mem ? mem_rdata_ff : m_rf_ff.val;

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_ff[m_rf_ff.idx] <= rf_wdata;
      end
   end

   // ------------------------------------------------- capture and operand read
   // port 1 reads rs1, port 2 reads rd for INC/ST/BEQZ and rs2 otherwise
   opcode_type req_op;
   logic [3:0] req_idx1;
   logic [3:0] req_idx2;

   assign req_op   = opcode_type'(req_tdata[15:12]);
   assign req_idx1 = req_tdata[7:4];
   assign req_idx2 = (req_op == OP_INC || req_op == OP_ST || req_op == OP_BEQZ) ?
                     req_tdata[11:8] : req_tdata[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (req_accept) begin
         e_valid_ff <= 1'b1;
      end else if (e_adv) begin
         e_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         e_kind_ff   <= kind_type'(req_tuser[1:0]);
         e_instr_ff  <= req_tdata[15:0];
         e_target_ff <= req_tdata[23:16];
         e_load_ff   <= req_tdata[31:24];
         // bypass the write that lands on this same edge
         e_src1_ff   <= (rf_we && m_rf_ff.idx == req_idx1) ? rf_wdata : rf_ff[req_idx1];
         e_src2_ff   <= (rf_we && m_rf_ff.idx == req_idx2) ? rf_wdata : rf_ff[req_idx2];
      end
   end

   // ------------------------------------------------------------- execute
   opcode_type  e_op;
   logic [3:0]  e_a, e_b, e_c;
   logic [3:0]  e_idx2;
   logic [7:0]  e_src1, e_src2;
   logic [15:0] e_prod;
   logic [7:0]  e_sra;
   logic [7:0]  e_ea;
   logic [7:0]  e_pc2;
   logic        mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]  mem_wdata;

   assign e_op   = opcode_type'(e_instr_ff[15:12]);
   assign e_a    = e_instr_ff[11:8];
   assign e_b    = e_instr_ff[7:4];
   assign e_c    = e_instr_ff[3:0];
   assign e_idx2 = (e_op == OP_INC || e_op == OP_ST || e_op == OP_BEQZ) ? e_a : e_c;

   // forward from the older word still in the result stage
   assign e_src1 = (m_valid_ff && m_rf_ff.we && m_rf_ff.idx == e_b) ? rf_wdata : e_src1_ff;
   assign e_src2 = (m_valid_ff && m_rf_ff.we && m_rf_ff.idx == e_idx2) ?
                   rf_wdata : e_src2_ff;

   assign e_prod = e_src1 * e_src2;
   assign e_sra  = 8'($signed(e_src1) >>> e_c);
   // rs1 plus the sign-extended 4-bit offset, wrapping at 8 bits
   assign e_ea   = e_src1 + {{4{e_c[3]}}, e_c};
   assign e_pc2  = pc_ff + PC_STEP;

   always_comb begin
      m_word_in  = '0;
      m_rf_in    = '0;
      m_rd_in    = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = mod_tbl[e_target_ff];
      mem_wdata  = e_load_ff;
      pc_in      = pc_ff;
      halt_in    = halt_ff;
      m_word_in.inst_class = CLASS_ARITH;

      unique case (e_kind_ff)
         KIND_LOAD_REG: begin
            m_rf_in.we  = 1'b1;
            m_rf_in.idx = e_target_ff[3:0];
            m_rf_in.val = e_load_ff;
         end
         KIND_LOAD_MEM: begin
            mem_we               = 1'b1;
            m_word_in.store_addr = 8'(mem_addr);
            m_word_in.store_byte = e_load_ff;
         end
         KIND_READ_MEM: begin
            mem_re               = 1'b1;
            m_rd_in              = 1'b1;
            m_word_in.store_addr = 8'(mem_addr);
         end
         KIND_EXEC: begin
            if (halt_ff) begin
               // halted machine ignores the instruction
               m_word_in.inst_class = CLASS_HALT;
            end else begin
               pc_in       = e_pc2;
               m_rf_in.idx = e_a;
               unique case (e_op)
                  OP_ADD: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_src1 + e_src2;
                  end
                  OP_SUB: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_src1 - e_src2;
                  end
                  OP_MUL: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_prod[7:0];
                  end
                  OP_INC: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_src2 + 8'd1;
                  end
                  OP_AND: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_src1 & e_src2;
                     m_word_in.inst_class = CLASS_LOGIC;
                  end
                  OP_OR: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_src1 | e_src2;
                     m_word_in.inst_class = CLASS_LOGIC;
                  end
                  OP_XOR: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_src1 ^ e_src2;
                     m_word_in.inst_class = CLASS_LOGIC;
                  end
                  OP_NOT: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = ~e_src1;
                     m_word_in.inst_class = CLASS_LOGIC;
                  end
                  OP_SLLI: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_src1 << e_c;
                     m_word_in.inst_class = CLASS_SHIFT;
                  end
                  OP_SRLI: begin
                     // arithmetic: counts of 8 and up leave only the sign
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_sra;
                     m_word_in.inst_class = CLASS_SHIFT;
                  end
                  OP_LI: begin
                     m_rf_in.we  = 1'b1;
                     m_rf_in.val = e_instr_ff[7:0];
                     m_word_in.inst_class = CLASS_IMM;
                  end
                  OP_LD: begin
                     m_rf_in.we       = 1'b1;
                     m_rf_in.from_mem = 1'b1;
                     mem_re           = 1'b1;
                     mem_addr         = mod_tbl[e_ea];
                     m_word_in.inst_class = CLASS_MEM;
                  end
                  OP_ST: begin
                     mem_we               = 1'b1;
                     mem_addr             = mod_tbl[e_ea];
                     mem_wdata            = e_src2;
                     m_word_in.store_done = 1'b1;
                     m_word_in.store_addr = 8'(mod_tbl[e_ea]);
                     m_word_in.store_byte = e_src2;
                     m_word_in.inst_class = CLASS_MEM;
                  end
                  OP_JMP: begin
                     // twice the signed 7-bit offset, modulo 256
                     pc_in = e_pc2 + {e_instr_ff[10:4], 1'b0};
                     m_word_in.inst_class = CLASS_CTRL;
                  end
                  OP_BEQZ: begin
                     if (e_src2 == 8'd0) begin
                        pc_in = e_pc2 + {e_instr_ff[6:0], 1'b0};
                     end
                     m_word_in.inst_class = CLASS_CTRL;
                  end
                  OP_HLT: begin
                     halt_in = 1'b1;
                     m_word_in.inst_class = CLASS_HALT;
                  end
               endcase
            end
         end
      endcase

      m_word_in.reg_written = m_rf_in.we && (e_kind_ff == KIND_EXEC);
      if (m_word_in.reg_written) begin
         m_word_in.dest_index = m_rf_in.idx;
         m_word_in.dest_value = m_rf_in.val;
      end
      m_word_in.next_pc = pc_in;
      m_word_in.halted  = halt_in;
   end

   // program counter and halt flag move as the word leaves execute
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else if (e_adv) begin
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
      end
   end

   // single-port data memory, read data registered
   always_ff @(posedge clock) begin
      if (e_adv) begin
         if (mem_we) begin
            data_mem[mem_addr] <= mem_wdata;
         end
         if (mem_re) begin
            mem_rdata_ff <= data_mem[mem_addr];
         end
      end
   end

   // ------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (e_adv) begin
         m_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         m_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (e_adv) begin
         m_word_ff <= m_word_in;
         m_rf_ff   <= m_rf_in;
         m_rd_ff   <= m_rd_in;
      end
   end

   rsp_word_type rsp_word;

   always_comb begin
      rsp_word = m_word_ff;
      if (m_rf_ff.from_mem) begin
         rsp_word.dest_value = mem_rdata_ff;
      end
      if (m_rd_ff) begin
         rsp_word.store_byte = mem_rdata_ff;
      end
   end

   assign rsp_tvalid = m_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_word);

   // ---------------------------------------------------------- assertions
   halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   pc_frozen_when_halted: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> $stable(pc_ff))
      else $error("program counter moved while halted");

   exec_reaches_result: assert property (@(posedge clock) disable iff (reset)
      e_adv |=> m_valid_ff)
      else $error("word left execute but no result is held");

   store_word_consistent: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && m_word_ff.store_done |->
         m_word_ff.inst_class == CLASS_MEM && !m_word_ff.reg_written)
      else $error("store result carries a register write or wrong class");

endmodule

/* tb/sv/t8cpu_exec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t8cpu_exec_checker
// watches both streams of the execute unit, predicts every result from its
// own copy of the registers, data memory, pc and halt flag, and compares
// ----------------------------------------------------------------------------
module t8cpu_exec_checker #(
   parameter int DATA_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [t8cpu_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [t8cpu_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [t8cpu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                                mismatch_count,
   output int                                pending_count,
   output int                                results_checked
);
   import t8cpu_pkg::*;

   logic [7:0] reg_copy [NUM_REGS];
   logic [7:0] mem_copy [DATA_DEPTH];
   logic [7:0] pc_copy;
   logic       halt_copy;

   rsp_word_type expected_results [$];

   int mismatches = 0;
   int pending    = 0;
   int checked    = 0;

   assign mismatch_count  = mismatches;
   assign pending_count   = pending;
   assign results_checked = checked;

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch: %s got %0h expected %0h (result %0d)", what, got, want, checked);
      mismatches++;
   endtask

   task automatic check_field(string what, logic [47:0] got, logic [47:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   function automatic logic [7:0] byte_index(logic [7:0] addr);
      return 8'(32'(addr) % DATA_DEPTH);
   endfunction

   // one word in, one result out; updates the local machine state
   function automatic rsp_word_type predict_execution(kind_type kind, logic [15:0] word,
                                                      logic [7:0] target, logic [7:0] value);
      rsp_word_type   r;
      opcode_type     op;
      inst_class_type cls;
      logic [3:0]     a, b, c;
      logic [7:0]     rs1, rs2, rdv, res, addr, next;
      logic           wr;
      r = '0;
      case (kind)
         KIND_LOAD_REG: reg_copy[target[3:0]] = value;
         KIND_LOAD_MEM: begin
            addr = byte_index(target);
            mem_copy[addr] = value;
            r.store_addr = addr;
            r.store_byte = value;
         end
         KIND_READ_MEM: begin
            addr = byte_index(target);
            r.store_addr = addr;
            r.store_byte = mem_copy[addr];
         end
         default: begin
            if (halt_copy) begin
               r.inst_class = CLASS_HALT;
            end else begin
               op   = opcode_type'(word[15:12]);
               a    = word[11:8];
               b    = word[7:4];
               c    = word[3:0];
               rs1  = reg_copy[b];
               rs2  = reg_copy[c];
               rdv  = reg_copy[a];
               next = pc_copy + PC_STEP;
               res  = '0;
               wr   = 1'b1;
               cls  = CLASS_ARITH;
               case (op)
                  OP_ADD:  res = rs1 + rs2;
                  OP_SUB:  res = rs1 - rs2;
                  OP_MUL:  res = rs1 * rs2;
                  OP_INC:  res = rdv + 8'd1;
                  OP_AND: begin res = rs1 & rs2; cls = CLASS_LOGIC; end
                  OP_OR: begin  res = rs1 | rs2; cls = CLASS_LOGIC; end
                  OP_XOR: begin res = rs1 ^ rs2; cls = CLASS_LOGIC; end
                  OP_NOT: begin res = ~rs1;      cls = CLASS_LOGIC; end
                  OP_SLLI: begin res = rs1 << c; cls = CLASS_SHIFT; end
                  OP_SRLI: begin res = 8'($signed(rs1) >>> c); cls = CLASS_SHIFT; end
                  OP_LI: begin  res = word[7:0]; cls = CLASS_IMM; end
                  OP_LD: begin
                     addr = byte_index(rs1 + {{4{c[3]}}, c});
                     res  = mem_copy[addr];
                     cls  = CLASS_MEM;
                  end
                  OP_ST: begin
                     addr = byte_index(rs1 + {{4{c[3]}}, c});
                     mem_copy[addr] = rdv;
                     wr           = 1'b0;
                     r.store_done = 1'b1;
                     r.store_addr = addr;
                     r.store_byte = rdv;
                     cls          = CLASS_MEM;
                  end
                  OP_JMP: begin
                     next = next + {word[10:4], 1'b0};
                     wr   = 1'b0;
                     cls  = CLASS_CTRL;
                  end
                  OP_BEQZ: begin
                     if (rdv == 8'd0)
                        next = next + {word[6:0], 1'b0};
                     wr  = 1'b0;
                     cls = CLASS_CTRL;
                  end
                  default: begin
                     halt_copy = 1'b1;
                     wr        = 1'b0;
                     cls       = CLASS_HALT;
                  end
               endcase
               if (wr) begin
                  reg_copy[a]   = res;
                  r.reg_written = 1'b1;
                  r.dest_index  = a;
                  r.dest_value  = res;
               end
               r.inst_class = cls;
               pc_copy      = next;
            end
         end
      endcase
      r.next_pc = pc_copy;
      r.halted  = halt_copy;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         pc_copy   = '0;
         halt_copy = 1'b0;
         expected_results.delete();
         pending <= 0;
      end else begin
         // results leave only after their word is taken, so pop first
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata[$bits(rsp_word_type)-1:0]);
            checked++;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_tdata, '0);
            end else begin
               want = expected_results.pop_front();
               check_field("next_pc", 48'(got.next_pc), 48'(want.next_pc));
               check_field("halted", 48'(got.halted), 48'(want.halted));
               check_field("reg_written", 48'(got.reg_written), 48'(want.reg_written));
               check_field("dest_index", 48'(got.dest_index), 48'(want.dest_index));
               check_field("dest_value", 48'(got.dest_value), 48'(want.dest_value));
               check_field("store_done", 48'(got.store_done), 48'(want.store_done));
               check_field("store_addr", 48'(got.store_addr), 48'(want.store_addr));
               check_field("store_byte", 48'(got.store_byte), 48'(want.store_byte));
               check_field("inst_class", 48'(got.inst_class), 48'(want.inst_class));
               check_field("tdata padding",
                           48'(rsp_tdata[RSP_TDATA_W-1:$bits(rsp_word_type)]), '0);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.insert(expected_results.size(),
               predict_execution(kind_type'(req_tuser), req_tdata[15:0],
                                 req_tdata[23:16], req_tdata[31:24]));
         pending <= expected_results.size();
      end
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the tiny 8-bit cpu execute unit: preloads the
// whole machine, runs directed corner words, a long random instruction mix
// with random gaps and backpressure, and finally the halt behavior
// ----------------------------------------------------------------------------
module tb;
   import t8cpu_pkg::*;

   localparam int DATA_DEPTH   = 256;
   localparam int RANDOM_WORDS = 1535;
   // worst case about 1850 words, each with the longest gap and the longest stall
   localparam int CYCLE_LIMIT  = 800000;
   // extra wait after the last result is checked, as margin
   localparam int DRAIN_CYCLES = 16;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int pending_count;
   int results_checked;
   int cycle_count = 0;
   int sent_by_kind [4];
   // words still to send back to back, with no gap on the req side
   int burst_left = 0;

   always #5 clock = ~clock;

   tiny_8bit_cpu_execute_unit #(
      .DATA_DEPTH(DATA_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   t8cpu_exec_checker #(
      .DATA_DEPTH(DATA_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .results_checked(results_checked)
   );

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // byte biased toward the values that break arithmetic
   function automatic logic [7:0] corner_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h7f;
         3: return 8'h80;
         4: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] encode(opcode_type op, logic [3:0] a, logic [3:0] b,
                                          logic [3:0] c);
      return {op, a, b, c};
   endfunction

   // present one word and hold it until the block takes it
   task automatic send_word(kind_type kind, logic [15:0] instr, logic [7:0] target,
                            logic [7:0] value);
      int gap;
      gap = (burst_left > 0) ? 0 : pick_gap();
      if (burst_left > 0)
         burst_left--;
      else if ($urandom_range(0, 99) == 0)
         burst_left = $urandom_range(30, 120);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      // tdata: instr_word [15:0], target_addr [23:16], load_value [31:24]
      req_tdata  <= {value, target, instr};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      sent_by_kind[kind]++;
   endtask

   // result side backpressure: runs of ready broken by stalls, with the odd
   // long stretch where the receiver never stalls
   initial begin : rsp_backpressure
      int run;
      int stall;
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int          roll;
      logic [15:0] noise;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // registers and data memory have no value until written, so fill both
      // first; every later read then sees a defined byte
      for (int i = 0; i < NUM_REGS; i++)
         send_word(KIND_LOAD_REG, 16'($urandom), {4'($urandom), 4'(i)}, corner_byte());
      for (int i = 0; i < DATA_DEPTH; i++)
         send_word(KIND_LOAD_MEM, 16'($urandom), 8'(i), corner_byte());

      // directed corners, register index taken from the low nibble only
      send_word(KIND_LOAD_REG, '0, 8'hf1, 8'h01);
      send_word(KIND_LOAD_REG, '0, 8'h02, 8'hff);
      send_word(KIND_LOAD_REG, '0, 8'h03, 8'h80);
      send_word(KIND_LOAD_REG, '0, 8'h00, 8'h00);
      // arithmetic wrap: ff + 1, 0 - 1, ff * ff, ff + 1 via inc
      send_word(KIND_EXEC, encode(OP_ADD, 4'd4, 4'd2, 4'd1), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_SUB, 4'd5, 4'd0, 4'd1), 8'hff, 8'hff);
      send_word(KIND_EXEC, encode(OP_MUL, 4'd6, 4'd2, 4'd2), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_INC, 4'd5, 4'd0, 4'd0), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_AND, 4'd7, 4'd2, 4'd3), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_OR, 4'd8, 4'd1, 4'd3), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_XOR, 4'd9, 4'd2, 4'd3), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_NOT, 4'd10, 4'd0, 4'd0), 8'h00, 8'h00);
      // shift counts past the byte width, and sign fill on the right shift
      send_word(KIND_EXEC, encode(OP_SLLI, 4'd11, 4'd2, 4'd15), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_SLLI, 4'd11, 4'd2, 4'd7), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_SRLI, 4'd12, 4'd3, 4'd15), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_SRLI, 4'd12, 4'd1, 4'd8), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_LI, 4'd13, 4'hf, 4'hf), 8'h00, 8'h00);
      // store at 0 - 8 and load at ff + 7, both wrapping the address
      send_word(KIND_EXEC, encode(OP_ST, 4'd2, 4'd0, 4'h8), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_LD, 4'd14, 4'd2, 4'h7), 8'h00, 8'h00);
      // jumps whose offset field is all zeros and all ones
      send_word(KIND_EXEC, encode(OP_JMP, 4'h8, 4'h0, 4'h0), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_JMP, 4'h7, 4'hf, 4'hf), 8'h00, 8'h00);
      // branch taken on zero, not taken otherwise
      send_word(KIND_EXEC, encode(OP_BEQZ, 4'd0, 4'h8, 4'h0), 8'h00, 8'h00);
      send_word(KIND_EXEC, encode(OP_BEQZ, 4'd1, 4'h7, 4'hf), 8'h00, 8'h00);
      send_word(KIND_LOAD_MEM, '0, 8'hff, 8'ha5);
      send_word(KIND_READ_MEM, '0, 8'hff, 8'h00);

      // random mix, no halt here since halt is sticky until reset
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         roll  = $urandom_range(0, 99);
         noise = 16'($urandom);
         if (roll < 78)
            send_word(KIND_EXEC, {opcode_type'($urandom_range(0, 14)), 12'($urandom)},
                      8'($urandom), 8'($urandom));
         else if (roll < 88)
            send_word(KIND_LOAD_REG, noise, 8'($urandom), corner_byte());
         else if (roll < 94)
            send_word(KIND_LOAD_MEM, noise, 8'($urandom), corner_byte());
         else
            send_word(KIND_READ_MEM, noise, 8'($urandom), 8'($urandom));
      end

      // halt, then check that nothing moves while preload and readout still work
      send_word(KIND_EXEC, encode(OP_HLT, 4'($urandom), 4'($urandom), 4'($urandom)),
                8'($urandom), 8'($urandom));
      for (int i = 0; i < 12; i++)
         send_word(KIND_EXEC, 16'($urandom), 8'($urandom), 8'($urandom));
      send_word(KIND_LOAD_REG, 16'($urandom), 8'($urandom), 8'($urandom));
      send_word(KIND_LOAD_MEM, 16'($urandom), 8'h42, 8'h5a);
      send_word(KIND_READ_MEM, 16'($urandom), 8'h42, 8'($urandom));
      send_word(KIND_EXEC, encode(OP_HLT, 4'hf, 4'hf, 4'hf), 8'hff, 8'hff);
      send_word(KIND_EXEC, encode(OP_ADD, 4'd1, 4'd2, 4'd3), 8'h00, 8'h00);
      req_tvalid <= 1'b0;

      // let the checker see the last word before asking what is still open
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered: %0d instructions, %0d register preloads,",
               sent_by_kind[KIND_EXEC], sent_by_kind[KIND_LOAD_REG]);
      $display("         %0d byte preloads, %0d readouts",
               sent_by_kind[KIND_LOAD_MEM], sent_by_kind[KIND_READ_MEM]);
      $display("compared %0d results, %0d mismatches, %0d cycles", results_checked,
               mismatch_count, cycle_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* tiny_8bit_cpu_execute_unit.f */
sv/t8cpu_pkg.sv
sv/tiny_8bit_cpu_execute_unit.sv
tb/sv/t8cpu_exec_checker.sv
tb/sv/tb.sv
